### src/ctcgd_pkg.sv
// Shared types and constants for the CTC greedy decoder.
// No dependencies.
package ctcgd_pkg;

  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [23:0] EXP_SUM_MAX = 24'hFFFFFF;
  localparam logic [7:0]  BLANK_RESET = 8'd76;
  localparam logic [4:0]  EXP_K_LIMIT = 5'd17;

  // Register index of blank_class on the config port.
  localparam logic REG_BLANK = 1'b0;

  // 2^-(2^-(j+1)) in Q16, j = 0..7
  localparam logic [15:0] POW2_NEG_Q16 [8] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757,
    16'd64132, 16'd64830, 16'd65182, 16'd65359
  };

  // One finished time step, front to back.
  typedef struct packed {
    logic [7:0]  winner;
    logic [23:0] exp_sum;
    logic        end_seq;
  } ctcgd_entry_t;

endpackage

### src/ctcgd_front.sv
// Front end: accepts scores, tracks max/argmax and the softmax exponent sum.
// Depends on ctcgd_pkg.
module ctcgd_front import ctcgd_pkg::*; #(
  parameter int NUM_CLASSES = 77
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_score,
  input  logic               in_last_in_step,
  input  logic               in_last_in_sequence,
  input  logic               q_full,
  output logic               q_push,
  output ctcgd_entry_t       q_entry
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_EXP  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  localparam logic [8:0] NUM_W = 9'(NUM_CLASSES);

  logic [2:0]         state_r;
  logic signed [15:0] s_r;
  logic               eos_r, eoq_r, first_r, inrange_r, gt_r;
  logic [32:0]        y_r;
  logic [16:0]        v_r;
  logic [2:0]         j_r;
  logic signed [15:0] max_r;
  logic [7:0]         arg_r, idx_r, cnt_r;
  logic [23:0]        sum_r;
  ctcgd_entry_t       pend_r;

  logic               accept;
  logic [15:0]        d;
  logic [32:0]        vm;
  logic [7:0]         r;
  logic [16:0]        e;
  logic [40:0]        prod;
  logic [24:0]        scaled;
  logic [25:0]        grow;
  logic [24:0]        add;
  logic [23:0]        sum_nxt;
  logic signed [15:0] max_nxt;
  logic [7:0]         arg_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign q_push   = (state_r == ST_PUSH) && !q_full;
  assign q_entry  = pend_r;

  always_comb begin
    d  = (s_r > max_r) ? 16'(s_r - max_r) : 16'(max_r - s_r);
    r  = y_r[23:16];
    vm = 33'(v_r * POW2_NEG_Q16[j_r]) + 33'd32768;
    e  = (y_r[32:24] >= 9'(EXP_K_LIMIT)) ? 17'd0 : (v_r >> y_r[28:24]);
    prod   = 41'(sum_r) * 41'(e);
    scaled = prod[40:16] + 25'(prod[15]);
    grow   = 26'(scaled) + 26'(ONE_Q16);
    add    = 25'(sum_r) + 25'(e);
    sum_nxt = sum_r;
    max_nxt = max_r;
    arg_nxt = arg_r;
    if (inrange_r) begin
      if (first_r) begin
        sum_nxt = 24'(ONE_Q16);
        max_nxt = s_r;
        arg_nxt = 8'd0;
      end else if (gt_r) begin
        sum_nxt = (grow > 26'(EXP_SUM_MAX)) ? EXP_SUM_MAX : grow[23:0];
        max_nxt = s_r;
        arg_nxt = idx_r;
      end else begin
        sum_nxt = (add > 25'(EXP_SUM_MAX)) ? EXP_SUM_MAX : add[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      max_r   <= '0;
      arg_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            s_r       <= in_score;
            eos_r     <= in_last_in_step;
            eoq_r     <= in_last_in_step && in_last_in_sequence;
            idx_r     <= cnt_r;
            first_r   <= (cnt_r == 8'd0);
            inrange_r <= ({1'b0, cnt_r} < NUM_W);
            if (cnt_r != 8'hFF) cnt_r <= cnt_r + 8'd1;
            if (cnt_r != 8'd0 && {1'b0, cnt_r} < NUM_W) state_r <= ST_CALC;
            else state_r <= ST_UPD;
          end
        end
        ST_CALC: begin
          gt_r    <= (s_r > max_r);
          y_r     <= 33'(d) * 33'(LOG2E_Q16);
          v_r     <= ONE_Q16;
          j_r     <= '0;
          state_r <= ST_EXP;
        end
        ST_EXP: begin
          if (r[3'd7 - j_r]) v_r <= vm[32:16];
          j_r <= j_r + 3'd1;
          if (j_r == 3'd7) state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (eos_r) begin
            pend_r.winner  <= arg_nxt;
            pend_r.exp_sum <= sum_nxt;
            pend_r.end_seq <= eoq_r;
            cnt_r   <= '0;
            max_r   <= '0;
            arg_r   <= '0;
            sum_r   <= '0;
            state_r <= ST_PUSH;
          end else begin
            max_r   <= max_nxt;
            arg_r   <= arg_nxt;
            sum_r   <= sum_nxt;
            state_r <= ST_IDLE;
          end
        end
        ST_PUSH: begin
          if (!q_full) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/ctcgd_queue.sv
// Two-entry queue of finished steps between front and back.
// Depends on ctcgd_pkg.
module ctcgd_queue import ctcgd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ctcgd_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output ctcgd_entry_t pop_entry,
  output logic         empty
);

  ctcgd_entry_t mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign pop_entry = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### src/ctcgd_back.sv
// Back end: CTC collapse, bit-serial 2^32/sum confidence, output register.
// Depends on ctcgd_pkg.
module ctcgd_back import ctcgd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [7:0]   blank_class,
  input  logic         q_empty,
  input  ctcgd_entry_t q_entry,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_has_char,
  output logic [7:0]   out_class_index,
  output logic [15:0]  out_confidence,
  output logic         out_end_of_sequence
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  state_r;
  logic [7:0]  prev_r;
  logic        started_r;
  logic [23:0] div_r, rem_r;
  logic [32:0] quo_r;
  logic [5:0]  it_r;
  logic        has_r, eoq_r;
  logic [7:0]  cls_r;
  logic        out_valid_r;

  logic [7:0]  prev;
  logic        keep;
  logic [24:0] rem_sh;
  logic        ge;
  logic        slot;

  assign prev   = started_r ? prev_r : blank_class;
  assign keep   = (q_entry.winner != blank_class) && (q_entry.winner != prev);
  assign q_pop  = (state_r == ST_IDLE) && !q_empty;
  assign rem_sh = {rem_r, (it_r == 6'd0)};
  assign ge     = (rem_sh >= {1'b0, div_r});
  assign slot   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= BLANK_RESET;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new load in ST_OUT takes over the slot being freed
      if (out_valid_r && !out_stall && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            prev_r    <= q_entry.end_seq ? blank_class : q_entry.winner;
            started_r <= !q_entry.end_seq;
            has_r     <= keep;
            cls_r     <= keep ? q_entry.winner : 8'd0;
            eoq_r     <= q_entry.end_seq;
            div_r     <= q_entry.exp_sum;
            rem_r     <= '0;
            quo_r     <= '0;
            it_r      <= '0;
            if (keep) state_r <= ST_DIV;
            else if (q_entry.end_seq) state_r <= ST_OUT;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? 24'(rem_sh - {1'b0, div_r}) : rem_sh[23:0];
          quo_r <= {quo_r[31:0], ge};
          it_r  <= it_r + 6'd1;
          if (it_r == 6'd32) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (slot) begin
            out_valid_r         <= 1'b1;
            out_has_char        <= has_r;
            out_class_index     <= cls_r;
            out_confidence      <= !has_r ? 16'd0 :
                                   (quo_r > 33'd65535) ? 16'hFFFF : quo_r[15:0];
            out_end_of_sequence <= eoq_r;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/ctc_greedy_decoder_unit.sv
// CTC greedy decoder: per-step argmax + softmax sum, collapse, 2^32/sum confidence.
// Flow: the first score of a step, or one with class index out of range, goes from accept
// straight to sum update; any other goes through accept, multiply, 8 exp iterations and sum update.
// A step end adds a queue push; a kept character then passes through the back end (pop,
// restoring divide, output load); the front runs on until the queue fills.
// Reset (rst_n, synchronous, active low) clears all step state; blank_class = 76.
module ctc_greedy_decoder_unit import ctcgd_pkg::*; #(
  parameter int NUM_CLASSES = 77
) (
  input  logic               clk,
  input  logic               rst_n,
  // score stream
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_score,
  input  logic               in_last_in_step,
  input  logic               in_last_in_sequence,
  // decoded characters
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_has_char,
  output logic [7:0]         out_class_index,
  output logic [15:0]        out_confidence,
  output logic               out_end_of_sequence,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]   blank_class_r;
  logic         q_push, q_pop, q_full, q_empty;
  ctcgd_entry_t push_entry, pop_entry;

  // Config: one register, index taken from paddr[2]; byte offset ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLANK) ? {24'd0, blank_class_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_class_r <= BLANK_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_BLANK) begin
      blank_class_r <= pwdata[7:0];
    end
  end

  // Front: one score at a time, pushes a summary at each step end.
  ctcgd_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_score            (in_score),
    .in_last_in_step     (in_last_in_step),
    .in_last_in_sequence (in_last_in_sequence),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_entry             (push_entry)
  );

  // Decouples the score stream from the divider.
  ctcgd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // Back: collapse, confidence, output register.
  ctcgd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .blank_class         (blank_class_r),
    .q_empty             (q_empty),
    .q_entry             (pop_entry),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_has_char        (out_has_char),
    .out_class_index     (out_class_index),
    .out_confidence      (out_confidence),
    .out_end_of_sequence (out_end_of_sequence)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue pop while empty");
  a_charless_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_char |-> out_end_of_sequence)
    else $error("charless result without end of sequence");
  a_charless_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_char |-> out_class_index == 8'd0 && out_confidence == 16'd0)
    else $error("charless result carries data");
`endif

endmodule

### bench/tb_ctc_greedy_decoder_unit.sv
// Self-checking bench for ctc_greedy_decoder_unit: score stream in, decoded classes out.
// Depends on ctcgd_pkg and the decoder RTL; its own step predictor builds the expected results.
module tb_ctc_greedy_decoder_unit import ctcgd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCLS = 77;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_ITEMS = 300;

  typedef struct packed {
    logic       has_char;
    logic [7:0] class_index;
    logic [15:0] confidence;
    logic       eos;
  } char_t;

  // one row of the directed score table; chk marks rows whose result is
  // typed in here and compared on top of the predictor
  typedef struct {
    logic signed [15:0] score;
    logic last_step;
    logic last_seq;
    logic chk;
    char_t want;
  } score_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_in_step, in_last_in_sequence;
  logic signed [15:0] in_score;
  logic out_valid, out_stall, out_has_char, out_end_of_sequence;
  logic [7:0] out_class_index;
  logic [15:0] out_confidence;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  ctc_greedy_decoder_unit dut (.*);

  // decoder model state
  logic [7:0]  m_blank;
  logic signed [15:0] m_max;
  logic [7:0]  m_argmax, m_count, m_prev;
  logic [23:0] m_sum;
  logic        m_started;

  char_t decoded_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;   // no idling in the last part of the run

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  // exp(-d), d in Q9.8, result Q1.16
  function automatic logic [16:0] exp_neg(input logic [16:0] d);
    logic [35:0] y;
    logic [7:0] r;
    logic [33:0] v;
    int k;
    y = d * 36'd94548;
    k = y >> 24;
    r = y[23:16];
    v = 34'd65536;
    for (int j = 0; j < 8; j++)
      if (r[7-j]) v = (v * POW2_NEG_Q16[j] + 34'd32768) >> 16;
    if (k >= 17) return 17'd0;
    return 17'(v >> k);
  endfunction

  function automatic logic [23:0] clip_sum(input logic [40:0] x);
    return (x > 41'hFFFFFF) ? 24'hFFFFFF : x[23:0];
  endfunction

  // advance the model by one score; queue a result when the step yields one
  task automatic decode_score(input logic signed [15:0] s, input logic ls, input logic lq);
    logic eseq, keep;
    logic [7:0] prv;
    logic [32:0] conf;
    char_t c;
    eseq = ls & lq;
    if (m_count < NCLS) begin
      if (m_count == 0) begin
        m_max = s; m_argmax = 0; m_sum = 24'd65536;
      end else if (s > m_max) begin
        m_sum = clip_sum(((41'(m_sum) * exp_neg(17'(s - m_max)) + 41'd32768) >> 16) + 41'd65536);
        m_max = s; m_argmax = m_count;
      end else begin
        m_sum = clip_sum(41'(m_sum) + exp_neg(17'(m_max - s)));
      end
    end
    if (m_count < 255) m_count++;
    if (!ls) return;
    prv = m_started ? m_prev : m_blank;
    keep = (m_argmax != m_blank) && (m_argmax != prv);
    conf = 65535;
    if (m_sum != 0) begin
      conf = 33'h100000000 / m_sum;
      if (conf > 65535) conf = 65535;
    end
    m_prev = m_argmax;
    m_started = 1;
    if (eseq) begin
      m_started = 0; m_prev = m_blank;
    end
    c.has_char = keep;
    c.class_index = keep ? m_argmax : 8'd0;
    c.confidence = keep ? conf[15:0] : 16'd0;
    c.eos = eseq;
    m_count = 0; m_max = 0; m_argmax = 0; m_sum = 0;
    if (keep || eseq) decoded_q = {decoded_q, c};
  endtask

  task automatic model_reset();
    m_blank = BLANK_RESET; m_max = 0; m_argmax = 0; m_count = 0;
    m_sum = 0; m_prev = BLANK_RESET; m_started = 0;
  endtask

  // APB write: setup then access; pready is always high
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 3'd0) m_blank = data[7:0];
    if (!m_started) m_prev = m_blank;
  endtask

  // the block may still be closing a step after the last result
  task automatic wait_drained();
    in_valid <= 0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // send one score request, with optional idle burst before it
  task automatic send_score(input logic signed [15:0] s, input logic ls, input logic lq);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1; in_score <= s; in_last_in_step <= ls; in_last_in_sequence <= lq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_score(s, ls, lq);
  endtask

  // one time step of n scores; winner biased toward class w
  task automatic send_step(input int n, input int w, input logic lq);
    logic signed [15:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: s = 16'($urandom);
        1: s = (i == w) ? 16'sd2000 : 16'($signed(12'($urandom)));
        default: s = (i == w) ? 16'($urandom_range(256, 3000)) : -16'($urandom_range(0, 1500));
      endcase
      send_score(s, i == n - 1, (i == n - 1) ? lq : ($urandom_range(0, 9) == 0));
    end
  endtask

  // receiver: random stall bursts, checks against the oldest expectation
  initial begin
    char_t e;
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (!rst_n) continue;
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report("unexpected result", out_class_index, 0);
        end else begin
          e = decoded_q.pop_front();
          if (out_has_char !== e.has_char) report("has_char", out_has_char, e.has_char);
          if (out_class_index !== e.class_index)
            report("class_index", out_class_index, e.class_index);
          if (out_confidence !== e.confidence)
            report("confidence", out_confidence, e.confidence);
          if (out_end_of_sequence !== e.eos)
            report("end_of_sequence", out_end_of_sequence, e.eos);
        end
      end
      if (!calm && !out_stall && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 3) - 1) @(posedge clk);
      end else begin
        out_stall <= 0;
      end
    end
  end

  // watchdog: cycles with no accepted score, no taken result and no config access
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  score_row_t rows[$];

  task automatic add_row(input logic signed [15:0] s, input logic ls, input logic lq,
                         input logic chk, input char_t want);
    score_row_t r;
    r.score = s; r.last_step = ls; r.last_seq = lq; r.chk = chk; r.want = want;
    rows = {rows, r};
  endtask

  initial begin
    char_t tail;
    int n;
    in_valid <= 0; in_score <= 0; in_last_in_step <= 0; in_last_in_sequence <= 0;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
    rst_n <= 0;
    model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table
    // one-score step ending the sequence: class 0 beats the blank start,
    // confidence saturates
    add_row(16'sd0, 1, 1, 1, {1'b1, 8'd0, 16'hFFFF, 1'b1});
    // new sequence: class 0 kept again
    add_row(16'sh7FFF, 1, 1, 1, {1'b1, 8'd0, 16'hFFFF, 1'b1});
    // extremes and a tie: first maximum wins
    add_row(-16'sd32768, 0, 1, 0, '0); // stray sequence mark
    add_row(16'sh7FFF, 0, 0, 0, '0);
    add_row(16'sh7FFF, 0, 0, 0, '0);
    add_row(-16'sd32768, 1, 0, 0, '0);
    // class 1 repeated twice, dropped both times
    add_row(16'sd0, 0, 0, 0, '0);
    add_row(16'sd512, 1, 0, 0, '0);
    add_row(16'sd100, 0, 0, 0, '0);
    add_row(16'sd300, 1, 0, 0, '0);
    // tie at class 0 closes the sequence
    add_row(16'sd5, 0, 0, 0, '0);
    add_row(16'sd5, 0, 0, 0, '0);
    add_row(16'sd0, 1, 1, 0, '0);
    foreach (rows[i]) begin
      send_score(rows[i].score, rows[i].last_step, rows[i].last_seq);
      if (rows[i].chk) begin
        tail = decoded_q[$];
        if (tail != rows[i].want) report("directed row", i, 0);
      end
    end
    // full step biased toward the blank, then beyond-class and over-long step
    send_step(NCLS, 76, 0);
    for (int i = 0; i < 300; i++) send_score(16'(i), i == 299, 1);
    wait_drained();

    // sweep the blank register: extremes, in range, out of range, an unused address, back to 76
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: cfg_write(3'd0, 32'd0);
        1: cfg_write(3'd0, 32'hFFFF_FFFF);
        2: cfg_write(3'd0, 32'd3);
        3: cfg_write(3'd4, 32'd9); // unused register
        default: cfg_write(3'd0, 32'd76);
      endcase
      n = 0;
      while (n < RAND_ITEMS / 5) begin
        int len;
        if ($urandom_range(0, 9) == 0) len = NCLS;
        else len = $urandom_range(1, 8);
        if (ph == 4 && n > RAND_ITEMS / 10) calm = 1;
        send_step(len, $urandom_range(0, len), $urandom_range(0, 4) == 0);
        n += len;
        if (ph == 1 && n > 40 && n < 50) wait_drained();
      end
      send_step(2, 0, 1);
      wait_drained();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
